// File: design/rhc_pkg.sv
// Package for the RGB to HSV converter: widths, scale constants, the hue
// sector codes and the work item that travels down the divider chain.
// No dependencies.
package rhc_pkg;

   // Full-scale value of saturation.
   localparam int unsigned SV_FULL_SCALE = 100;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned RGB_W   = 3 * CHAN_W;
   localparam int unsigned QUO_W   = 10;
   localparam int unsigned ACC_W   = CHAN_W + QUO_W;
   localparam int unsigned DIV_STEPS = QUO_W;
   localparam int unsigned HUE_W   = 9;
   localparam int unsigned SAT_W   = 10;
   localparam int unsigned HUE_CALC_W = 11;

   localparam int HUE_SCALE = 60;
   localparam int HUE_GREEN = 120;
   localparam int HUE_BLUE  = 240;
   localparam int HUE_WRAP  = 360;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } rhc_sector_type;

   // One division: the upper CHAN_W bits of acc hold the partial remainder,
   // the lower QUO_W bits hold dividend bits still to come and, from the
   // bottom, the quotient bits already found.
   typedef struct packed {
      logic [ACC_W-1:0]  acc;
      logic [CHAN_W-1:0] divisor;
   } rhc_lane_type;

   typedef struct packed {
      rhc_lane_type      sat;
      rhc_lane_type      hue;
      logic              hue_neg;
      rhc_sector_type    sector;
      logic              sat_zero;
      logic              hue_zero;
      logic [CHAN_W-1:0] bright;
   } rhc_work_type;

endpackage

// File: design/rhc_front.sv
// Entry stage of the converter: splits the colour, finds the largest and
// smallest channel and forms both dividends and divisors.
// Depends on rhc_pkg.
module rhc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             valid_in,
   input  logic [rhc_pkg::RGB_W-1:0]        color_in,
   input  logic                             ready_down,
   output logic                             ready_up,
   output logic                             valid_ff,
   output rhc_pkg::rhc_work_type            work_ff
);
   import rhc_pkg::*;

   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] grn;
   logic [CHAN_W-1:0] blu;
   logic [CHAN_W-1:0] hi;
   logic [CHAN_W-1:0] lo;
   logic [CHAN_W-1:0] span;
   logic [CHAN_W-1:0] op_a;
   logic [CHAN_W-1:0] op_b;
   logic [CHAN_W-1:0] mag;
   rhc_sector_type    sector;
   rhc_work_type      work_in;

   assign red = color_in[3*CHAN_W-1:2*CHAN_W];
   assign grn = color_in[2*CHAN_W-1:CHAN_W];
   assign blu = color_in[CHAN_W-1:0];

   always_comb begin
      hi = red;
      if (grn > hi) begin
         hi = grn;
      end
      if (blu > hi) begin
         hi = blu;
      end
      lo = red;
      if (grn < lo) begin
         lo = grn;
      end
      if (blu < lo) begin
         lo = blu;
      end
      span = hi - lo;

      // Ties go to red first, then green.
      if (hi == red) begin
         sector = SECTOR_RED;
      end else if (hi == grn) begin
         sector = SECTOR_GREEN;
      end else begin
         sector = SECTOR_BLUE;
      end

      case (sector)
         SECTOR_RED: begin
            op_a = grn;
            op_b = blu;
         end
         SECTOR_GREEN: begin
            op_a = blu;
            op_b = red;
         end
         default: begin
            op_a = red;
            op_b = grn;
         end
      endcase
      mag = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

      work_in.sat.acc     = ACC_W'(span) * ACC_W'(SV_FULL_SCALE);
      work_in.sat.divisor = hi;
      work_in.hue.acc     = ACC_W'(mag) * ACC_W'(HUE_SCALE);
      work_in.hue.divisor = span;
      work_in.hue_neg     = (op_a < op_b);
      work_in.sector      = sector;
      work_in.sat_zero    = (hi == '0);
      work_in.hue_zero    = (span == '0);
      work_in.bright      = hi;
   end

   assign ready_up = !valid_ff || ready_down;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up && valid_in) begin
         work_ff <= work_in;
      end
   end

endmodule

// File: design/rhc_div_cell.sv
// One cell of the divider chain: finds one quotient bit of the saturation
// division and one of the hue division, then hands the item on.
// Depends on rhc_pkg.
module rhc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  rhc_pkg::rhc_work_type work_prev,
   input  logic                  ready_down,
   output logic                  ready_up,
   output logic                  valid_ff,
   output rhc_pkg::rhc_work_type work_ff
);
   import rhc_pkg::*;

   rhc_work_type work_in;

   // Restoring step: bring down the next dividend bit, subtract when it fits.
   function automatic rhc_lane_type div_step(input rhc_lane_type lane);
      logic [CHAN_W:0]   trial;
      logic [CHAN_W:0]   diff;
      logic              fits;
      logic [CHAN_W-1:0] rem;
      rhc_lane_type      res;
      trial = {lane.acc[ACC_W-1:QUO_W], lane.acc[QUO_W-1]};
      diff  = trial - {1'b0, lane.divisor};
      fits  = (trial >= {1'b0, lane.divisor});
      rem   = fits ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
      res.acc     = {rem, lane.acc[QUO_W-2:0], fits};
      res.divisor = lane.divisor;
      return res;
   endfunction

   always_comb begin
      work_in     = work_prev;
      work_in.sat = div_step(work_prev.sat);
      work_in.hue = div_step(work_prev.hue);
   end

   assign ready_up = !valid_ff || ready_down;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_up) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up && valid_in) begin
         work_ff <= work_in;
      end
   end

endmodule

// File: design/rgb_to_hsv_convert_top.sv
// Integer RGB to HSV converter: entry stage, a row of divider cells with
// one quotient bit per cell, and a registered output stage that fixes hue.
// Path from an accepted beat to its result on rsp_valid: entry stage,
// DIV_STEPS = 10 divider cells, output register.
// Throughput: one beat per cycle; each stage holds its own beat, so the
// input keeps flowing until the chain fills behind a stalled result.
// Reset: synchronous, clears every stage's valid bit; no payload reset.
module rgb_to_hsv_convert_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rhc_pkg::RGB_W-1:0]     req_color_rgb,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rhc_pkg::HUE_W-1:0]     rsp_hue,
   output logic [rhc_pkg::SAT_W-1:0]     rsp_saturation,
   output logic [rhc_pkg::CHAN_W-1:0]    rsp_brightness
);
   import rhc_pkg::*;

   logic         stage_valid [0:DIV_STEPS];
   rhc_work_type stage_work  [0:DIV_STEPS];
   logic         down_ready  [0:DIV_STEPS];
   logic         front_ready;

   logic                         rsp_valid_ff;
   logic [HUE_W-1:0]             rsp_hue_ff;
   logic [SAT_W-1:0]             rsp_saturation_ff;
   logic [CHAN_W-1:0]            rsp_brightness_ff;
   logic [HUE_W-1:0]             rsp_hue_in;
   logic [SAT_W-1:0]             rsp_saturation_in;
   logic                         out_ready;
   logic signed [HUE_CALC_W-1:0] hue_raw;
   logic signed [HUE_CALC_W-1:0] hue_wrapped;
   logic [QUO_W-1:0]             hue_quo;
   rhc_work_type                 last_work;

   rhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (req_valid),
      .color_in   (req_color_rgb),
      .ready_down (down_ready[0]),
      .ready_up   (front_ready),
      .valid_ff   (stage_valid[0]),
      .work_ff    (stage_work[0])
   );

   assign req_stall = !front_ready;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rhc_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .valid_in   (stage_valid[i]),
         .work_prev  (stage_work[i]),
         .ready_down (down_ready[i+1]),
         .ready_up   (down_ready[i]),
         .valid_ff   (stage_valid[i+1]),
         .work_ff    (stage_work[i+1])
      );
   end

   assign out_ready            = !rsp_valid_ff || !rsp_stall;
   assign down_ready[DIV_STEPS] = out_ready;
   assign last_work            = stage_work[DIV_STEPS];

   // The quotient magnitude is at most 60, so the sector offset and one
   // wrap by a full turn bring the hue into range.
   always_comb begin
      hue_quo = last_work.hue.acc[QUO_W-1:0];
      if (last_work.hue_neg) begin
         hue_raw = -$signed({1'b0, hue_quo});
      end else begin
         hue_raw = $signed({1'b0, hue_quo});
      end
      case (last_work.sector)
         SECTOR_GREEN: hue_raw = hue_raw + HUE_CALC_W'(HUE_GREEN);
         SECTOR_BLUE:  hue_raw = hue_raw + HUE_CALC_W'(HUE_BLUE);
         default:      hue_raw = hue_raw;
      endcase
      if (hue_raw < 0) begin
         hue_wrapped = hue_raw + HUE_CALC_W'(HUE_WRAP);
      end else begin
         hue_wrapped = hue_raw;
      end
      rsp_hue_in = last_work.hue_zero ? '0 : hue_wrapped[HUE_W-1:0];
      rsp_saturation_in = last_work.sat_zero ? '0 : last_work.sat.acc[SAT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stage_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stage_valid[DIV_STEPS]) begin
         rsp_hue_ff        <= rsp_hue_in;
         rsp_saturation_ff <= rsp_saturation_in;
         rsp_brightness_ff <= last_work.bright;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_saturation_ff;
   assign rsp_brightness = rsp_brightness_ff;

endmodule

// File: dv/testbench.sv
// Testbench for rgb_to_hsv_convert_top: corner colours first, then random colours under
// several idle patterns, a long output hold-off and a full drain pause.
// Depends on rhc_pkg and the converter RTL only.
`timescale 1ns / 100ps

module testbench;
   import rhc_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_beat_type;

   typedef struct {
      logic [RGB_W-1:0] color;
      hsv_beat_type     hsv;
   } pending_hsv_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [RGB_W-1:0]    req_color_rgb;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [HUE_W-1:0]    rsp_hue;
   logic [SAT_W-1:0]    rsp_saturation;
   logic [CHAN_W-1:0]   rsp_brightness;

   pending_hsv_type hsv_pending[$];
   int mismatches    = 0;
   int cycles        = 0;
   int send_gap_pct  = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   rgb_to_hsv_convert_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_color_rgb  (req_color_rgb),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Integer HSV of one packed colour; the hue sector follows the largest channel,
   // with red winning ties over green and green over blue.
   function automatic hsv_beat_type rgb_to_hsv(logic [RGB_W-1:0] rgb);
      int red, grn, blu, top, bottom, span, num, hue_deg;
      hsv_beat_type res;
      red = int'(rgb[23:16]);
      grn = int'(rgb[15:8]);
      blu = int'(rgb[7:0]);
      top = red;
      bottom = red;
      if (grn > top) top = grn;
      if (blu > top) top = blu;
      if (grn < bottom) bottom = grn;
      if (blu < bottom) bottom = blu;
      span = top - bottom;
      hue_deg = 0;
      res = '0;
      if (top > 0) begin
         res.saturation = SAT_W'((span * int'(SV_FULL_SCALE)) / top);
         if (span > 0) begin
            // Signed integer division truncates toward zero, as the hue needs.
            if (top == red) begin
               num = (grn - blu) * HUE_SCALE;
               hue_deg = num / span;
            end else if (top == grn) begin
               num = (blu - red) * HUE_SCALE;
               hue_deg = num / span + HUE_GREEN;
            end else begin
               num = (red - grn) * HUE_SCALE;
               hue_deg = num / span + HUE_BLUE;
            end
         end
         if (hue_deg < 0) hue_deg += HUE_WRAP;
         else if (hue_deg >= HUE_WRAP) hue_deg -= HUE_WRAP;
      end
      res.hue = hue_deg[HUE_W-1:0];
      res.brightness = top[CHAN_W-1:0];
      return res;
   endfunction

   // Checks each result beat against the oldest prediction, then records any input beat.
   always @(posedge clock) begin
      pending_hsv_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hsv_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with none expected: hue %0d sat %0d bright %0d",
                        $time, rsp_hue, rsp_saturation, rsp_brightness);
         end else begin
            want = hsv_pending.pop_front();
            if (want.hsv.hue !== rsp_hue || want.hsv.saturation !== rsp_saturation ||
                want.hsv.brightness !== rsp_brightness) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: rgb %06h expected hue %0d sat %0d bright %0d, got %0d %0d %0d",
                           $time, want.color, want.hsv.hue, want.hsv.saturation,
                           want.hsv.brightness, rsp_hue, rsp_saturation, rsp_brightness);
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         want.color = req_color_rgb;
         want.hsv = rgb_to_hsv(req_color_rgb);
         hsv_pending.push_back(want);
      end
   end

   // Result-side stall: a requested hold-off takes priority over random stalls.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_gap_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   // Offers one colour and returns at the edge where the beat is taken.
   task automatic send_color(input logic [RGB_W-1:0] rgb);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_color_rgb <= rgb;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_results;
      @(posedge clock);
      while (hsv_pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [RGB_W-1:0] random_color();
      logic [CHAN_W-1:0] a, b, c;
      a = CHAN_W'($urandom);
      b = CHAN_W'($urandom);
      c = CHAN_W'($urandom);
      case ($urandom_range(9))
         5: return {a, a, a};
         6: return {8'hFF, 8'hFF, c};
         7: return {6'd0, a[1:0], 6'd0, b[1:0], 6'd0, c[1:0]};
         8: return {a[0] ? 8'hFF : 8'h00, b, c[0] ? 8'hFF : 8'h00};
         9: begin
            case ($urandom_range(2))
               0: return {a, a, c};
               1: return {a, c, a};
               default: return {c, a, a};
            endcase
         end
         default: return RGB_W'($urandom);
      endcase
   endfunction

   task automatic test_corner_colors;
      send_color(24'h000000);
      send_color(24'hFFFFFF);
      send_color(24'h808080);
      send_color(24'h010101);
      send_color(24'hFF0000);
      send_color(24'h00FF00);
      send_color(24'h0000FF);
      // Ties for the largest channel: red beats green, green beats blue, red beats blue.
      send_color(24'hFFFF00);
      send_color(24'h00FFFF);
      send_color(24'hFF00FF);
      // Red sector with a negative hue that wraps, and one that truncates to zero.
      send_color(24'hFF0080);
      send_color(24'hFF0001);
      send_color(24'h10FF20);
      send_color(24'h2010FF);
      send_color(24'h4020FF);
      send_color(24'h010000);
      send_color(24'h000001);
      send_color(24'h020103);
      send_color(24'h7F80FE);
      send_color(24'hC83264);
   endtask

   task automatic test_random_colors(input int count);
      repeat (count) send_color(random_color());
   endtask

   // The result side holds off for a long stretch while colours keep coming,
   // so the converter fills and stalls its input.
   task automatic test_output_hold_off;
      hold_requests <= hold_requests + 1;
      repeat (80) send_color(random_color());
   endtask

   // The sender stops until every outstanding result has arrived, then resumes.
   task automatic test_drain_pause;
      repeat (30) send_color(random_color());
      req_valid <= 1'b0;
      wait_for_results();
      repeat (30) send_color(random_color());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_color_rgb = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_corner_colors();
      set_idling(16, 58);
      test_random_colors(460);
      set_idling(58, 16);
      test_random_colors(460);
      set_idling(0, 0);
      test_output_hold_off();
      test_drain_pause();
      test_random_colors(390);

      req_valid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && hsv_pending.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
design/rhc_pkg.sv
design/rhc_front.sv
design/rhc_div_cell.sv
design/rgb_to_hsv_convert_top.sv
dv/testbench.sv
